// File: design/dsv_pkg.sv
// Shared types and constants for the date string validator.
`default_nettype none

package dsv_pkg;

    typedef enum logic [1:0] {
        PH_YEAR,
        PH_MONTH,
        PH_DAY
    } t_phase;

    localparam logic [7:0]  CHR_ZERO      = 8'h30;
    localparam logic [7:0]  CHR_NINE      = 8'h39;
    localparam logic [7:0]  CHR_DASH      = 8'h2D;
    localparam logic [7:0]  CHR_SLASH     = 8'h2F;
    localparam logic [7:0]  CHR_DOT       = 8'h2E;
    localparam logic [13:0] MIN_YEAR_RST  = 14'd1900;
    localparam logic [2:0]  ADDR_MIN_YEAR = 3'd0;
    localparam logic [2:0]  YEAR_DIGITS   = 3'd4;
    localparam logic [2:0]  FIELD_DIGITS  = 3'd2;
    localparam logic [3:0]  MONTH_FEB     = 4'd2;
    localparam logic [3:0]  MONTH_DEC     = 4'd12;

    function automatic logic [4:0] month_len(input logic [3:0] month);
        logic [4:0] len;
        case (month)
            4'd1:    len = 5'd31;
            4'd2:    len = 5'd28;
            4'd3:    len = 5'd31;
            4'd4:    len = 5'd30;
            4'd5:    len = 5'd31;
            4'd6:    len = 5'd30;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd31;
            4'd9:    len = 5'd30;
            4'd10:   len = 5'd31;
            4'd11:   len = 5'd30;
            4'd12:   len = 5'd31;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// File: design/date_string_validator_core.sv
// Date string validator: character parser with date range and leap year check.
`default_nettype none

// The block takes one character word per cycle, back to back, and gives one
// result word for each string on the word marked as last. A character passes
// through an input register, the next parser state and the date check come from
// combinational logic, and the result lands in an output register, so a
// result is registered when its last character leaves the input register. The input
// side stalls only when a last character finds the output register full.
// The year is kept both in binary and as four decimal digits, so the leap
// year rule needs no division.
module date_string_validator_core
    import dsv_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_char_code,
    input  wire logic        i_is_last,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_valid_res,
    output logic      [13:0] o_year_out,
    output logic      [3:0]  o_month_out,
    output logic      [4:0]  o_day_out
);

    logic [13:0] r_min_year;

    logic        r_in_vld;
    logic [7:0]  r_char;
    logic        r_last;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_cnt, n_cnt;
    logic [7:0]  r_sep, n_sep;
    logic [13:0] r_year, n_year;
    logic [15:0] r_ybcd, n_ybcd;
    logic [6:0]  r_month, n_month;
    logic [6:0]  r_day, n_day;
    logic        r_err, n_err;

    logic        r_out_vld;
    logic        r_res_ok;
    logic [13:0] r_res_year;
    logic [3:0]  r_res_month;
    logic [4:0]  r_res_day;

    logic        is_digit;
    logic        is_sep;
    logic [3:0]  dval;
    logic        cent;
    logic        leap;
    logic [1:0]  low_mod4;
    logic [1:0]  high_mod4;
    logic [4:0]  max_day;
    logic        date_ok;
    logic        slot_free;
    logic        s1_fire;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MIN_YEAR) ? {18'd0, r_min_year} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_year <= MIN_YEAR_RST;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_MIN_YEAR) begin
            r_min_year <= pwdata[13:0];
        end
    end

    assign slot_free  = !r_out_vld || i_out_ready;
    assign s1_fire    = r_in_vld && (!r_last || slot_free);
    assign o_in_ready = !r_in_vld || s1_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_char <= i_char_code;
            r_last <= i_is_last;
        end
    end

    always_comb begin
        is_digit = (r_char >= CHR_ZERO) && (r_char <= CHR_NINE);
        is_sep   = (r_char == CHR_DASH) || (r_char == CHR_SLASH) || (r_char == CHR_DOT);
        dval     = r_char[3:0];

        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_sep   = r_sep;
        n_year  = r_year;
        n_ybcd  = r_ybcd;
        n_month = r_month;
        n_day   = r_day;
        n_err   = r_err;

        if (!r_err) begin
            case (r_phase)
                PH_YEAR: begin
                    if (is_digit && r_cnt < YEAR_DIGITS) begin
                        n_year = 14'(r_year * 14'd10) + 14'(dval);
                        n_ybcd = {r_ybcd[11:0], dval};
                        n_cnt  = r_cnt + 3'd1;
                    end else if (is_sep && r_cnt == YEAR_DIGITS) begin
                        n_sep   = r_char;
                        n_phase = PH_MONTH;
                        n_cnt   = 3'd0;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                PH_MONTH: begin
                    if (is_digit && r_cnt < FIELD_DIGITS) begin
                        n_month = 7'(r_month * 7'd10) + 7'(dval);
                        n_cnt   = r_cnt + 3'd1;
                    end else if (r_char == r_sep && r_cnt != 3'd0) begin
                        n_phase = PH_DAY;
                        n_cnt   = 3'd0;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                PH_DAY: begin
                    if (is_digit && r_cnt < FIELD_DIGITS) begin
                        n_day = 7'(r_day * 7'd10) + 7'(dval);
                        n_cnt = r_cnt + 3'd1;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                default: begin
                    n_err = 1'b1;
                end
            endcase
        end

        // A valid date always has exactly four year digits, so the digit
        // register holds the whole year: thousands in the top nibble.
        cent      = (n_ybcd[7:0] == 8'd0);
        low_mod4  = {n_ybcd[4], 1'b0} + n_ybcd[1:0];
        high_mod4 = {n_ybcd[12], 1'b0} + n_ybcd[9:8];
        leap      = (low_mod4 == 2'd0 && !cent) || (cent && high_mod4 == 2'd0);
        max_day   = month_len(n_month[3:0])
                  + {4'd0, (n_month == 7'(MONTH_FEB)) && leap};
        date_ok   = !n_err && n_phase == PH_DAY && n_cnt != 3'd0
                  && n_year >= r_min_year
                  && n_month >= 7'd1 && n_month <= 7'(MONTH_DEC)
                  && n_day >= 7'd1 && n_day <= {2'd0, max_day};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_YEAR;
            r_cnt   <= 3'd0;
            r_sep   <= 8'd0;
            r_year  <= 14'd0;
            r_ybcd  <= 16'd0;
            r_month <= 7'd0;
            r_day   <= 7'd0;
            r_err   <= 1'b0;
        end else if (s1_fire) begin
            if (r_last) begin
                r_phase <= PH_YEAR;
                r_cnt   <= 3'd0;
                r_sep   <= 8'd0;
                r_year  <= 14'd0;
                r_ybcd  <= 16'd0;
                r_month <= 7'd0;
                r_day   <= 7'd0;
                r_err   <= 1'b0;
            end else begin
                r_phase <= n_phase;
                r_cnt   <= n_cnt;
                r_sep   <= n_sep;
                r_year  <= n_year;
                r_ybcd  <= n_ybcd;
                r_month <= n_month;
                r_day   <= n_day;
                r_err   <= n_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_fire && r_last) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_last) begin
            r_res_ok    <= date_ok;
            r_res_year  <= date_ok ? n_year : 14'd0;
            r_res_month <= date_ok ? n_month[3:0] : 4'd0;
            r_res_day   <= date_ok ? n_day[4:0] : 5'd0;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_valid_res = r_res_ok;
    assign o_year_out  = r_res_year;
    assign o_month_out = r_res_month;
    assign o_day_out   = r_res_day;

    a_valid_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_res_ok) |-> (r_res_month >= 4'd1 && r_res_month <= MONTH_DEC
            && r_res_day != 5'd0 && r_res_year >= r_min_year))
        else $error("valid result with out-of-range fields");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_res_ok) |-> (r_res_year == 14'd0 && r_res_month == 4'd0
            && r_res_day == 5'd0))
        else $error("invalid result with nonzero fields");

    a_parser_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_last) |=> (r_phase == PH_YEAR && r_cnt == 3'd0 && !r_err
            && r_year == 14'd0 && r_month == 7'd0 && r_day == 7'd0))
        else $error("parser not cleared after last word");

    a_digit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt <= YEAR_DIGITS) && (r_phase == PH_YEAR || r_cnt <= FIELD_DIGITS))
        else $error("digit count out of range");

endmodule

`default_nettype wire
